/* design/isd_pkg.sv */
// ----------------------------------------------------------------------------
// isd_pkg
// Shared widths, constants and types of the IMU stuck detector.
// ----------------------------------------------------------------------------
package isd_pkg;

    // field widths
    localparam int AXIS_W     = 16;
    localparam int DIFF_W     = 17;
    localparam int SQ_W       = 32;
    localparam int SUMSQ_W    = 34;
    localparam int ROOT_W     = 17;
    localparam int MOVE_W     = 18;
    localparam int TS_W       = 32;
    localparam int THR_W      = 18;
    localparam int TMO_W      = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    localparam int DEFAULT_WINDOW_LEN = 8;

    // register reset values
    localparam logic [THR_W-1:0] THR_RESET = 18'd819;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd2000;

    // one g in accel counts
    localparam logic signed [DIFF_W-1:0] ONE_G = 17'sd16384;

    // gravity window on 25 * sum of squares: 2^32 < 25*S < 98304^2
    localparam int GRAV_W = 39;
    localparam logic [GRAV_W-1:0] GRAV_LO = 39'd4294967296;
    localparam logic [GRAV_W-1:0] GRAV_HI = 39'd9663676416;

    // gyro scaling: floor(g * 4096 / 3275) by reciprocal and one correction
    localparam int GYRO_DIV      = 3275;
    localparam int GYRO_SHIFT    = 12;
    localparam int GYRO_RECIP_SH = 20;
    localparam int GYRO_RECIP_W  = 21;
    localparam logic [GYRO_RECIP_W-1:0] GYRO_RECIP =
        GYRO_RECIP_W'((64'd1 << (GYRO_SHIFT + GYRO_RECIP_SH)) / 64'd3275);

    localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

    // recovery stage limits in ms
    localparam logic [TS_W-1:0] STAGE1_LIMIT = 32'd3000;
    localparam logic [TS_W-1:0] STAGE2_LIMIT = 32'd6000;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_OFF_X  = 3'd0,
        REG_ACCEL_OFF_Y  = 3'd1,
        REG_ACCEL_OFF_Z  = 3'd2,
        REG_GYRO_OFF_X   = 3'd3,
        REG_GYRO_OFF_Y   = 3'd4,
        REG_GYRO_OFF_Z   = 3'd5,
        REG_MOVE_THR     = 3'd6,
        REG_STUCK_TMO    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STAGE_NONE    = 2'd0,
        STAGE_REVERSE = 2'd1,
        STAGE_ROTATE  = 2'd2,
        STAGE_ESTOP   = 2'd3
    } stage_t;

    typedef struct packed {
        logic [AXIS_W-1:0] accel_off_x;
        logic [AXIS_W-1:0] accel_off_y;
        logic [AXIS_W-1:0] accel_off_z;
        logic [AXIS_W-1:0] gyro_off_x;
        logic [AXIS_W-1:0] gyro_off_y;
        logic [AXIS_W-1:0] gyro_off_z;
        logic [THR_W-1:0]  move_threshold;
        logic [TMO_W-1:0]  stuck_tmo;
    } cfg_t;

    // one classified sample handed from front to back
    typedef struct packed {
        logic [SUMSQ_W-1:0] accel_ss;
        logic [SUMSQ_W-1:0] gyro_ss;
        logic               motors;
        logic [TS_W-1:0]    ts;
    } sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ_A,
        F_SQ_G,
        F_GRAV,
        F_SQ_Z,
        F_SUM_Z,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROOT,
        B_FIX,
        B_MERGE,
        B_AVG,
        B_AVG_FIX,
        B_EMIT
    } back_state_t;

endpackage

/* design/imu_stuck_detector_top.sv */
// ----------------------------------------------------------------------------
// imu_stuck_detector_top
// IMU stuck detector: movement estimate from accel and gyro samples and a
// stuck timer with recovery stage while the motors are driven.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one raw accel/gyro sample with motors flag and ms time
//   stamp per transaction (valid/ready). Result channel m_*: one transaction
//   per sample with stuck flag, stuck_ms, movement and recovery_stage.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
//   write only while no sample is in flight.
//   The front part offsets, squares and gravity-checks one sample at a time;
//   the back part, paced by the 17-step square root units, takes a new
//   sample from the queue only after it has loaded the last result into
//   the output register.
//   A two-entry queue sits between front and back; a result waits in the
//   output register while the receiver stalls, and the back part stops only
//   when it needs that register again; the front part keeps accepting until
//   the queue is full.
//   Reset (aresetn low, synchronous) clears the averaging window, the stuck
//   timer and the configuration registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module imu_stuck_detector_top #(
    parameter int WINDOW_LEN = isd_pkg::DEFAULT_WINDOW_LEN
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [isd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [isd_pkg::AXIS_W-1:0]   s_accel_x,
    input  logic signed [isd_pkg::AXIS_W-1:0]   s_accel_y,
    input  logic signed [isd_pkg::AXIS_W-1:0]   s_accel_z,
    input  logic signed [isd_pkg::AXIS_W-1:0]   s_gyro_x,
    input  logic signed [isd_pkg::AXIS_W-1:0]   s_gyro_y,
    input  logic signed [isd_pkg::AXIS_W-1:0]   s_gyro_z,
    input  logic                                s_motors_active,
    input  logic [isd_pkg::TS_W-1:0]            s_timestamp_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_stuck_flag,
    output logic [isd_pkg::TS_W-1:0]            m_stuck_ms,
    output logic [isd_pkg::MOVE_W-1:0]          m_movement,
    output logic [1:0]                          m_recovery_stage
);
    import isd_pkg::*;

    cfg_t        cfg_reg;
    logic        q_push;
    logic        q_pop;
    sample_t     q_wdata;
    sample_t     q_rdata;
    queue_stat_t q_stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= {{(6*AXIS_W){1'b0}}, THR_RESET, TMO_RESET};
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_ACCEL_OFF_X: cfg_reg.accel_off_x    <= cfg_wdata[AXIS_W-1:0];
                REG_ACCEL_OFF_Y: cfg_reg.accel_off_y    <= cfg_wdata[AXIS_W-1:0];
                REG_ACCEL_OFF_Z: cfg_reg.accel_off_z    <= cfg_wdata[AXIS_W-1:0];
                REG_GYRO_OFF_X:  cfg_reg.gyro_off_x     <= cfg_wdata[AXIS_W-1:0];
                REG_GYRO_OFF_Y:  cfg_reg.gyro_off_y     <= cfg_wdata[AXIS_W-1:0];
                REG_GYRO_OFF_Z:  cfg_reg.gyro_off_z     <= cfg_wdata[AXIS_W-1:0];
                REG_MOVE_THR:    cfg_reg.move_threshold <= cfg_wdata[THR_W-1:0];
                REG_STUCK_TMO:   cfg_reg.stuck_tmo      <= cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    isd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_accel_x       (s_accel_x),
        .s_accel_y       (s_accel_y),
        .s_accel_z       (s_accel_z),
        .s_gyro_x        (s_gyro_x),
        .s_gyro_y        (s_gyro_y),
        .s_gyro_z        (s_gyro_z),
        .s_motors_active (s_motors_active),
        .s_timestamp_ms  (s_timestamp_ms),
        .q_push          (q_push),
        .q_data          (q_wdata),
        .q_stat          (q_stat)
    );

    isd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    isd_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_pop            (q_pop),
        .q_data           (q_rdata),
        .q_stat           (q_stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_stuck_flag     (m_stuck_flag),
        .m_stuck_ms       (m_stuck_ms),
        .m_movement       (m_movement),
        .m_recovery_stage (m_recovery_stage)
    );

    // recovery stage is set exactly when stuck is reported
    a_stage_iff_stuck: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_stuck_flag == (m_recovery_stage != STAGE_NONE)))
        else $error("recovery stage disagrees with stuck flag");

    // emergency stop only after the second stage limit
    a_estop_late: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_recovery_stage == STAGE_ESTOP)) |-> (m_stuck_ms >= STAGE2_LIMIT))
        else $error("emergency stop before stage limit");

    // front never pushes into a full queue, back never pops an empty one
    a_queue_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
        else $error("queue overflow or underflow");

endmodule

/* design/isd_isqrt.sv */
// ----------------------------------------------------------------------------
// isd_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module isd_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [isd_pkg::SUMSQ_W-1:0]  operand,
    output logic                         done,
    output logic [isd_pkg::ROOT_W-1:0]   root
);
    import isd_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    logic [SUMSQ_W-1:0] op_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;

    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               take;

    // next two operand bits joined to the remainder, trial is 4*root + 1
    always_comb begin
        rem_sh = {rem_reg, op_reg[SUMSQ_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        take   = rem_sh >= trial;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            op_reg <= {op_reg[SUMSQ_W-3:0], 2'b00};
            if (take) begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* design/isd_queue.sv */
// ----------------------------------------------------------------------------
// isd_queue
// Short FIFO of classified samples between the front and back parts.
// ----------------------------------------------------------------------------
module isd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  isd_pkg::sample_t       push_data,
    input  logic                   pop,
    output isd_pkg::sample_t       pop_data,
    output isd_pkg::queue_stat_t   stat
);
    import isd_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    sample_t           entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = count_reg == QCNT_FULL;
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = entry_mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/isd_front.sv */
// ----------------------------------------------------------------------------
// isd_front
// Accepts samples, removes offsets, squares the axes and applies the
// gravity window to Z before handing the sums of squares to the queue.
// ----------------------------------------------------------------------------
module isd_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  isd_pkg::cfg_t                     cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [isd_pkg::AXIS_W-1:0] s_accel_x,
    input  logic signed [isd_pkg::AXIS_W-1:0] s_accel_y,
    input  logic signed [isd_pkg::AXIS_W-1:0] s_accel_z,
    input  logic signed [isd_pkg::AXIS_W-1:0] s_gyro_x,
    input  logic signed [isd_pkg::AXIS_W-1:0] s_gyro_y,
    input  logic signed [isd_pkg::AXIS_W-1:0] s_gyro_z,
    input  logic                              s_motors_active,
    input  logic [isd_pkg::TS_W-1:0]          s_timestamp_ms,
    output logic                              q_push,
    output isd_pkg::sample_t                  q_data,
    input  isd_pkg::queue_stat_t              q_stat
);
    import isd_pkg::*;

    function automatic logic signed [DIFF_W-1:0] sub_off(input logic [AXIS_W-1:0] raw,
                                                         input logic [AXIS_W-1:0] off);
        return $signed({raw[AXIS_W-1], raw}) - $signed({off[AXIS_W-1], off});
    endfunction

    function automatic logic [SQ_W-1:0] sq17(input logic signed [DIFF_W-1:0] d);
        logic signed [2*DIFF_W-1:0] p;
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

    front_state_t              state_reg;
    front_state_t              state_next;
    logic signed [DIFF_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [DIFF_W-1:0]  gx_reg, gy_reg, gz_reg;
    logic [SQ_W-1:0]           sq_reg [3];
    logic [SUMSQ_W-1:0]        acc_ss_reg;
    logic [SUMSQ_W-1:0]        gyr_ss_reg;
    logic                      motors_reg;
    logic [TS_W-1:0]           ts_reg;

    logic                      accept;
    logic signed [DIFF_W-1:0]  mul_op [3];
    logic [SUMSQ_W-1:0]        sq_sum;
    logic [GRAV_W-1:0]         s25;
    logic                      in_grav;

    assign accept = s_valid && s_ready;

    // three squaring lanes, shared between accel and gyro
    always_comb begin
        if (state_reg == F_SQ_G) begin
            mul_op[0] = gx_reg;
            mul_op[1] = gy_reg;
            mul_op[2] = gz_reg;
        end else begin
            mul_op[0] = ax_reg;
            mul_op[1] = ay_reg;
            mul_op[2] = az_reg;
        end
    end

    // sum of squares and gravity window test (25*S by shift-and-add)
    always_comb begin
        sq_sum  = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        s25     = ({5'b0, acc_ss_reg} << 4) + ({5'b0, acc_ss_reg} << 3)
                + {5'b0, acc_ss_reg};
        in_grav = (s25 > GRAV_LO) && (s25 < GRAV_HI);
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = F_SQ_A;
            end
            F_SQ_A:  state_next = F_SQ_G;
            F_SQ_G:  state_next = F_GRAV;
            F_GRAV:  state_next = F_SQ_Z;
            F_SQ_Z:  state_next = F_SUM_Z;
            F_SUM_Z: state_next = F_PUSH;
            F_PUSH: begin
                if (!q_stat.full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    ax_reg     <= sub_off(s_accel_x, cfg.accel_off_x);
                    ay_reg     <= sub_off(s_accel_y, cfg.accel_off_y);
                    az_reg     <= sub_off(s_accel_z, cfg.accel_off_z);
                    gx_reg     <= sub_off(s_gyro_x, cfg.gyro_off_x);
                    gy_reg     <= sub_off(s_gyro_y, cfg.gyro_off_y);
                    gz_reg     <= sub_off(s_gyro_z, cfg.gyro_off_z);
                    motors_reg <= s_motors_active;
                    ts_reg     <= s_timestamp_ms;
                end
            end
            F_SQ_A, F_SQ_Z: begin
                for (int i = 0; i < 3; i++) sq_reg[i] <= sq17(mul_op[i]);
            end
            F_SQ_G: begin
                acc_ss_reg <= sq_sum;
                for (int i = 0; i < 3; i++) sq_reg[i] <= sq17(mul_op[i]);
            end
            F_GRAV: begin
                gyr_ss_reg <= sq_sum;
                // remove one g from Z toward zero; zero Z stays as is
                if (in_grav) begin
                    if (az_reg > 17'sd0) begin
                        az_reg <= az_reg - ONE_G;
                    end else if (az_reg < 17'sd0) begin
                        az_reg <= az_reg + ONE_G;
                    end
                end
            end
            F_SUM_Z: begin
                acc_ss_reg <= sq_sum;
            end
            default: ;
        endcase
    end

    assign q_data.accel_ss = acc_ss_reg;
    assign q_data.gyro_ss  = gyr_ss_reg;
    assign q_data.motors   = motors_reg;
    assign q_data.ts       = ts_reg;

endmodule

/* design/isd_back.sv */
// ----------------------------------------------------------------------------
// isd_back
// Takes classified samples from the queue: square roots, gyro scaling,
// moving-average window, stuck timer and the result register.
// ----------------------------------------------------------------------------
module isd_back #(
    parameter int WINDOW_LEN = isd_pkg::DEFAULT_WINDOW_LEN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  isd_pkg::cfg_t                 cfg,
    output logic                          q_pop,
    input  isd_pkg::sample_t              q_data,
    input  isd_pkg::queue_stat_t          q_stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_stuck_flag,
    output logic [isd_pkg::TS_W-1:0]      m_stuck_ms,
    output logic [isd_pkg::MOVE_W-1:0]    m_movement,
    output logic [1:0]                    m_recovery_stage
);
    import isd_pkg::*;

    localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = MOVE_W + $clog2(WINDOW_LEN);
    localparam int APROD_W = 2 * SUM_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0] WIN_LEN_C = SUM_W'(WINDOW_LEN);
    // floor(2^SUM_W / WINDOW_LEN): quotient estimate is short by at most one
    localparam logic [SUM_W:0] AVG_RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / WINDOW_LEN);
    localparam int GPROD_W = ROOT_W + GYRO_RECIP_W;
    localparam int GNUM_W  = 30;
    localparam logic [GNUM_W-1:0] GYRO_DIV_C = GNUM_W'(GYRO_DIV);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic                   motors_reg;
    logic [TS_W-1:0]        ts_reg;
    logic [GPROD_W-1:0]     gprod_reg;
    logic [MOVE_W-1:0]      gq_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic [WINDOW_LEN-1:0]  valid_reg;
    logic [MOVE_W-1:0]      win_mem [WINDOW_LEN];
    logic [MOVE_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;
    logic [APROD_W-1:0]     aprod_reg;
    logic [MOVE_W-1:0]      aq_reg;
    logic                   moving_reg;
    logic                   active_reg;
    logic [TS_W-1:0]        start_reg;
    logic                   m_valid_reg;
    logic                   stuck_flag_reg;
    logic [TS_W-1:0]        stuck_ms_reg;
    logic [MOVE_W-1:0]      movement_reg;
    stage_t                 stage_reg;

    logic                   a_done;
    logic                   g_done;
    logic [ROOT_W-1:0]      a_root;
    logic [ROOT_W-1:0]      g_root;
    logic                   out_load;

    logic [MOVE_W-1:0]      gq0;
    logic [GNUM_W-1:0]      gnum;
    logic [GNUM_W-1:0]      grem;
    logic [MOVE_W:0]        m_raw;
    logic [MOVE_W-1:0]      m_val;
    logic [MOVE_W-1:0]      old_val;
    logic [MOVE_W-1:0]      aq0;
    logic [SUM_W-1:0]       arem;
    logic [SUM_W-1:0]       thr;

    logic                   run;
    logic [TS_W-1:0]        start_eff;
    logic [TS_W-1:0]        dur;
    logic                   stuck;
    stage_t                 stage;

    // accel and gyro roots run side by side
    isd_isqrt u_sqrt_accel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (q_pop),
        .operand (q_data.accel_ss),
        .done    (a_done),
        .root    (a_root)
    );

    isd_isqrt u_sqrt_gyro (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (q_pop),
        .operand (q_data.gyro_ss),
        .done    (g_done),
        .root    (g_root)
    );

    // gyro scale correction, movement merge, average correction
    always_comb begin
        gq0     = gprod_reg[GYRO_RECIP_SH +: MOVE_W];
        gnum    = {1'b0, g_root, {GYRO_SHIFT{1'b0}}};
        grem    = gnum - GNUM_W'({12'b0, gq0} * GYRO_DIV_C);
        m_raw   = {2'b00, a_root} + {1'b0, gq_reg};
        m_val   = m_raw[MOVE_W] ? MOVE_MAX : m_raw[MOVE_W-1:0];
        old_val = rd_valid_reg ? rd_data_reg : '0;
        aq0     = aprod_reg[SUM_W +: MOVE_W];
        arem    = sum_reg - SUM_W'(SUM_W'(aq0) * WIN_LEN_C);
        thr     = SUM_W'(SUM_W'(cfg.move_threshold) * WIN_LEN_C);
    end

    // stuck timer and recovery stage
    always_comb begin
        run       = motors_reg && !moving_reg;
        start_eff = active_reg ? start_reg : ts_reg;
        dur       = run ? ts_reg - start_eff : '0;
        stuck     = run && (dur >= {16'b0, cfg.stuck_tmo});
        if (!stuck) begin
            stage = STAGE_NONE;
        end else if (dur < STAGE1_LIMIT) begin
            stage = STAGE_REVERSE;
        end else if (dur < STAGE2_LIMIT) begin
            stage = STAGE_ROTATE;
        end else begin
            stage = STAGE_ESTOP;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    state_next = B_ROOT;
                end
            end
            B_ROOT: begin
                if (a_done && g_done) state_next = B_FIX;
            end
            B_FIX:     state_next = B_MERGE;
            B_MERGE:   state_next = B_AVG;
            B_AVG:     state_next = B_AVG_FIX;
            B_AVG_FIX: state_next = B_EMIT;
            B_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            sum_reg     <= '0;
            ptr_reg     <= '0;
            valid_reg   <= '0;
            active_reg  <= 1'b0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_MERGE) begin
                sum_reg            <= sum_reg - SUM_W'(old_val) + SUM_W'(m_val);
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            end
            if (out_load) begin
                active_reg  <= run;
                start_reg   <= run ? start_eff : '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window memory, read every cycle at the current slot
    always_ff @(posedge aclk) begin
        if (state_reg == B_MERGE) begin
            win_mem[ptr_reg] <= m_val;
        end
        rd_data_reg  <= win_mem[ptr_reg];
        rd_valid_reg <= valid_reg[ptr_reg];
    end

    // payload datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            motors_reg <= q_data.motors;
            ts_reg     <= q_data.ts;
        end
        if (state_reg == B_ROOT) begin
            gprod_reg <= GPROD_W'(g_root) * GPROD_W'(GYRO_RECIP);
        end
        if (state_reg == B_FIX) begin
            gq_reg <= (grem >= GYRO_DIV_C) ? gq0 + 1'b1 : gq0;
        end
        if (state_reg == B_AVG) begin
            aprod_reg <= APROD_W'(sum_reg) * APROD_W'(AVG_RECIP);
        end
        if (state_reg == B_AVG_FIX) begin
            aq_reg     <= (arem >= WIN_LEN_C) ? aq0 + 1'b1 : aq0;
            moving_reg <= sum_reg > thr;
        end
        if (out_load) begin
            stuck_flag_reg <= stuck;
            stuck_ms_reg   <= dur;
            movement_reg   <= aq_reg;
            stage_reg      <= stage;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_stuck_flag     = stuck_flag_reg;
    assign m_stuck_ms       = stuck_ms_reg;
    assign m_movement       = movement_reg;
    assign m_recovery_stage = stage_reg;

endmodule
